// File: hw/rtl/lfu_pkg.sv
// shared types and constants for the lfu page replacement block
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int FRAMES_DEF    = 4;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_W   = 3;
  localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

  localparam int IN_W    = 16;
  localparam int AGE_W   = 8;
  localparam int USES_W  = 8;
  localparam int FAULT_W = 16;
  localparam int STAT_W  = 2;
  localparam int IDX_OUT_W = 2;
  localparam int EVICT_W = 16;
  localparam int OUT_W   = 40;

  localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
  localparam logic [USES_W-1:0]  USES_MAX  = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT   = 2'd0,
    ST_FILL  = 2'd1,
    ST_FAULT = 2'd2
  } lfu_status_t;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } lfu_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } lfu_cmd_t;

endpackage

// File: hw/rtl/lfu_page_replacement.sv
// top level of the lfu page replacement block
// Each page reference word is worked on in steps: first the page is registered, then all
// frames in use are compared against it, the victim is picked by a comparison tree and the
// frame table is written back together with the result word. While a result word waits on
// m_tready the block holds in its compare step, and it takes no new word until the current
// one is committed. frames_in_use may only be written while no word is in flight.
`timescale 1ns / 1ps

module lfu_page_replacement #(
  parameter int FRAMES    = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wr_data,  // frames_in_use
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [lfu_pkg::IN_W-1:0]  s_tdata,      // page_number
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lfu_pkg::OUT_W-1:0] m_tdata       // status, frame_index, evicted_page,
                                                  // fault_count, zero pad
);

  lfu_pkg::lfu_cmd_t cmd;

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lfu_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_page     (s_tdata),
    .cmd         (cmd),
    .out_word    (m_tdata)
  );

endmodule

// File: hw/rtl/lfu_ctrl.sv
// controller: takes a word, then commits the frame update and the result word
`timescale 1ns / 1ps

module lfu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output lfu_pkg::lfu_cmd_t cmd
);

  lfu_pkg::lfu_state_t state;
  lfu_pkg::lfu_state_t state_next;
  logic                out_full;
  logic                slot_free;

  assign slot_free = !out_full || m_tready;
  assign m_tvalid  = out_full;

  always_comb begin
    state_next = state;
    unique case (state)
      lfu_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = lfu_pkg::S_EVAL;
        end
      end
      lfu_pkg::S_EVAL: begin
        if (slot_free) begin
          state_next = lfu_pkg::S_IDLE;
        end
      end
      default: state_next = lfu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      lfu_pkg::S_IDLE: begin
        s_tready = !rst;
        cmd.load = !rst && s_tvalid;
      end
      lfu_pkg::S_EVAL: begin
        cmd.commit = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lfu_pkg::S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_full <= 1'b1;
      end else if (m_tready) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/lfu_datapath.sv
// datapath: frame table, match scan, victim tree, counters and result word
`timescale 1ns / 1ps

module lfu_datapath #(
  parameter int FRAMES    = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lfu_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [lfu_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic [lfu_pkg::IN_W-1:0]   in_page,
  input  lfu_pkg::lfu_cmd_t          cmd,
  output logic [lfu_pkg::OUT_W-1:0]  out_word
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > lfu_pkg::CFG_W) ? CNT_W : lfu_pkg::CFG_W;
  localparam int P2    = 1 << IDX_W;
  localparam int KEY_W = 1 + lfu_pkg::USES_W + lfu_pkg::AGE_W;

  logic [lfu_pkg::CFG_W-1:0]   frames_in_use;
  logic [PAGE_BITS-1:0]        page_reg;
  logic [PAGE_BITS-1:0]        frame_page [FRAMES];
  logic [FRAMES-1:0]           frame_valid;
  logic [lfu_pkg::AGE_W-1:0]   frame_age  [FRAMES];
  logic [lfu_pkg::USES_W-1:0]  frame_uses [FRAMES];
  logic [lfu_pkg::FAULT_W-1:0] faults_total;
  logic [lfu_pkg::FAULT_W-1:0] faults_next;

  logic [31+lfu_pkg::IN_W:0]   page_wide;
  logic [CMP_W-1:0]            cfg_ext;
  logic [CMP_W-1:0]            active;
  logic [FRAMES-1:0]           in_scope;
  logic [FRAMES-1:0]           stop;
  logic [FRAMES-1:0]           passed;
  logic [FRAMES-1:0]           dec_onehot;
  logic                        found;
  logic                        dec_hit;
  logic [IDX_W-1:0]            dec_idx;
  logic [lfu_pkg::AGE_W-1:0]   aged_age [FRAMES];

  logic [KEY_W-1:0]            node_key [2*P2];
  logic [IDX_W-1:0]            node_idx [2*P2];
  logic [IDX_W-1:0]            victim;
  logic [PAGE_BITS-1:0]        victim_page;

  logic [PAGE_BITS+15:0]       evict_wide;
  logic [IDX_W+1:0]            idx_wide;
  logic [IDX_W-1:0]            where;
  lfu_pkg::lfu_status_t        status;

  assign page_wide = {32'b0, in_page};

  // clamp of the frame count
  always_comb begin
    cfg_ext = CMP_W'(frames_in_use);
    if (cfg_ext == '0) begin
      active = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      active = CMP_W'(FRAMES);
    end else begin
      active = cfg_ext;
    end
  end

  // first empty or matching frame in scan order
  always_comb begin
    found      = 1'b0;
    dec_idx    = '0;
    dec_onehot = '0;
    passed     = '0;
    for (int j = 0; j < FRAMES; j++) begin
      in_scope[j] = CMP_W'(j) < active;
      stop[j]     = in_scope[j] &&
                    (!frame_valid[j] || (frame_page[j] == page_reg));
      aged_age[j] = (frame_age[j] != lfu_pkg::AGE_MAX) ?
                    frame_age[j] + 1'b1 : frame_age[j];
      if (!found) begin
        if (stop[j]) begin
          found         = 1'b1;
          dec_idx       = IDX_W'(j);
          dec_onehot[j] = 1'b1;
        end else begin
          passed[j] = in_scope[j];
        end
      end
    end
    dec_hit = |(dec_onehot & frame_valid);
  end

  // victim tree: lowest count, then oldest, then lowest index
  always_comb begin
    for (int i = 0; i < P2; i++) begin
      node_idx[P2+i] = IDX_W'(i);
      node_key[P2+i] = '1;
      if (i < FRAMES) begin
        if (in_scope[i]) begin
          node_key[P2+i] = {1'b0, frame_uses[i], ~aged_age[i]};
        end
      end
    end
    node_key[0] = '1;
    node_idx[0] = '0;
    for (int k = P2 - 1; k >= 1; k--) begin
      if (node_key[2*k+1] < node_key[2*k]) begin
        node_key[k] = node_key[2*k+1];
        node_idx[k] = node_idx[2*k+1];
      end else begin
        node_key[k] = node_key[2*k];
        node_idx[k] = node_idx[2*k];
      end
    end
    victim = node_idx[1];
  end

  always_comb begin
    victim_page = '0;
    for (int j = 0; j < FRAMES; j++) begin
      if (victim == IDX_W'(j)) begin
        victim_page = frame_page[j];
      end
    end
  end

  always_comb begin
    faults_next = faults_total;
    if (!found && faults_total != lfu_pkg::FAULT_MAX) begin
      faults_next = faults_total + 1'b1;
    end
    if (found) begin
      where  = dec_idx;
      status = dec_hit ? lfu_pkg::ST_HIT : lfu_pkg::ST_FILL;
      evict_wide = '0;
    end else begin
      where  = victim;
      status = lfu_pkg::ST_FAULT;
      evict_wide = {16'b0, victim_page};
    end
    idx_wide = {2'b0, where};
  end

  // control state of the frames
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lfu_pkg::CFG_RESET;
      frame_valid   <= '0;
      faults_total  <= '0;
      for (int j = 0; j < FRAMES; j++) begin
        frame_age[j]  <= '0;
        frame_uses[j] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      if (cmd.commit) begin
        faults_total <= faults_next;
        for (int j = 0; j < FRAMES; j++) begin
          if (passed[j] && (found || victim != IDX_W'(j))) begin
            frame_age[j] <= aged_age[j];
          end
          if (dec_onehot[j]) begin
            if (dec_hit) begin
              frame_age[j] <= '0;
              if (frame_uses[j] != lfu_pkg::USES_MAX) begin
                frame_uses[j] <= frame_uses[j] + 1'b1;
              end
            end else begin
              frame_valid[j] <= 1'b1;
              frame_age[j]   <= lfu_pkg::AGE_W'(1);
              frame_uses[j]  <= '0;
            end
          end
          if (!found && victim == IDX_W'(j)) begin
            frame_age[j]  <= '0;
            frame_uses[j] <= '0;
          end
        end
      end
    end
  end

  // page numbers and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_reg <= page_wide[PAGE_BITS-1:0];
    end
    if (cmd.commit) begin
      for (int j = 0; j < FRAMES; j++) begin
        if ((dec_onehot[j] && !dec_hit) || (!found && victim == IDX_W'(j))) begin
          frame_page[j] <= page_reg;
        end
      end
      out_word <= {4'b0, faults_next, evict_wide[lfu_pkg::EVICT_W-1:0],
                   idx_wide[lfu_pkg::IDX_OUT_W-1:0], status};
    end
  end

endmodule

// File: hw/rtl/lfu_checker.sv
// port checks for the lfu page replacement block, bound to the top level
`timescale 1ns / 1ps

module lfu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [lfu_pkg::OUT_W-1:0] m_tdata
);

  // after a word is taken, s_tready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed under stall");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == lfu_pkg::ST_HIT) || (m_tdata[1:0] == lfu_pkg::ST_FILL) ||
                 (m_tdata[1:0] == lfu_pkg::ST_FAULT))
    else $error("unknown status code");

  // only a replacement names an evicted page
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != lfu_pkg::ST_FAULT) |-> m_tdata[19:4] == 16'd0)
    else $error("evicted page on hit or fill");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
